// ----- sv/ccd_pkg.sv -----
// Shared types and constants for the minimum coin change block.
// No dependencies; imported by ccd_seq and min_coin_change_dp.
package ccd_pkg;

   localparam int MAX_AMOUNT = 1023;
   localparam int MAX_COINS  = 6;
   localparam int AMT_W      = 10;
   localparam int CNT_W      = 11;
   localparam int KIDX_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int TBL_DEPTH  = MAX_AMOUNT + 1;
   localparam int TBL_AW     = $clog2(TBL_DEPTH);

   // Table code for an amount that no coin mix reaches.
   localparam logic [CNT_W-1:0] INF_CODE = '1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_A     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_F     = 3'd6;

   typedef logic [MAX_COINS-1:0][AMT_W-1:0] coin_set_type;

   // One access pair to the scratch table.
   typedef struct packed {
      logic              wr_en;
      logic [TBL_AW-1:0] wr_addr;
      logic [CNT_W-1:0]  wr_data;
      logic              rd_en;
      logic [TBL_AW-1:0] rd_addr;
   } mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INIT = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } seq_state_type;

endpackage

// ----- sv/ccd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ccd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/ccd_seq.sv -----
// Table rebuild sequencer: walks amounts and coins, reads the table, keeps the
// running minimum and writes each entry back. Depends on ccd_pkg.
module ccd_seq
   import ccd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [AMT_W-1:0]   target,
   input  logic [KIDX_W-1:0]  n_active,
   input  coin_set_type       coins,
   input  logic [CNT_W-1:0]   rd_data,
   input  logic               take,
   output mem_req_type        mem_req,
   output logic               idle,
   output logic               done,
   output logic [CNT_W-1:0]   result
);

   seq_state_type      state_ff, state_in;
   logic [AMT_W-1:0]   target_ff, target_in;
   logic [AMT_W-1:0]   amt_ff, amt_in;
   logic [KIDX_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]   acc_ff, acc_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   result_ff, result_in;

   logic [AMT_W-1:0]   coin_sel;
   logic               coin_use;
   logic               k_live;
   logic [CNT_W-1:0]   cand;
   logic [CNT_W-1:0]   acc_next;

   assign k_live   = (k_ff < n_active);
   assign coin_sel = k_live ? coins[k_ff] : '0;
   assign coin_use = k_live && (coin_sel != '0) && (coin_sel <= amt_ff);

   // Candidate from the entry read in the previous cycle.
   always_comb begin
      cand = INF_CODE;
      if (pend_ff && (rd_data != INF_CODE)) begin
         cand = rd_data + CNT_W'(1);
      end
   end
   assign acc_next = (cand < acc_ff) ? cand : acc_ff;

   always_comb begin
      state_in  = state_ff;
      target_in = target_ff;
      amt_in    = amt_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      pend_in   = 1'b0;
      result_in = result_ff;
      mem_req   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               target_in = target;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = '0;
            mem_req.wr_data = '0;
            if (target_ff == '0) begin
               result_in = '0;
               state_in  = ST_DONE;
            end else begin
               amt_in   = AMT_W'(1);
               k_in     = '0;
               acc_in   = INF_CODE;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (k_live) begin
               mem_req.rd_en   = coin_use;
               mem_req.rd_addr = TBL_AW'(amt_ff - coin_sel);
               pend_in         = coin_use;
               acc_in          = acc_next;
               k_in            = k_ff + KIDX_W'(1);
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = TBL_AW'(amt_ff);
               mem_req.wr_data = acc_next;
               k_in            = '0;
               acc_in          = INF_CODE;
               if (amt_ff == target_ff) begin
                  result_in = acc_next;
                  state_in  = ST_DONE;
               end else begin
                  amt_in = amt_ff + AMT_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      target_ff <= target_in;
      amt_ff    <= amt_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign idle   = (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_DONE);
   assign result = result_ff;

   // Reads and writes never share a cycle, so no same-entry hazard arises.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("table read and write in the same cycle");

   // A pending candidate always comes from a read issued in the previous cycle.
   a_pend_has_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(mem_req.rd_en))
      else $error("candidate without a table read");

   // The scan never runs past the target or touches amount zero.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (amt_ff != '0 && amt_ff <= target_ff))
      else $error("scan amount out of range");

   // Every read address lies strictly below the amount being built.
   a_read_below: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> (mem_req.rd_addr < TBL_AW'(amt_ff)))
      else $error("table read at or above current amount");

endmodule

// ----- sv/min_coin_change_dp.sv -----
// Top level of the minimum coin change block: configuration registers, result
// register, scratch table RAM and the rebuild sequencer. Depends on ccd_pkg,
// ccd_ram and ccd_seq.
//
// For each target amount item the block rebuilds best[0..target] in a
// 1024 x 11 RAM and answers the fewest coins and a reachable flag. For each
// amount it steps through the n active coins, where n is the saturated coin
// count (at most 6), reads the table through the single read port for each
// usable coin and then writes the entry back. A zero target answers zero
// coins, reachable. The result sits in an output register, so the next item
// is accepted while the previous result waits. Configuration registers are
// written through csr_*; the user must write them only while the block is
// idle, which the block itself does not enforce. Index 0 is coin_count (only
// the low three bits are kept, 7 saturates to 6), 1..6 are coin_a to coin_f,
// a zero coin is ignored, other indexes are dropped.
module min_coin_change_dp
   import ccd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [AMT_W-1:0]     req_target_amount,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [AMT_W-1:0]     rsp_min_coins,
   output logic                 rsp_reachable,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [AMT_W-1:0]     csr_wdata
);

   logic [KIDX_W-1:0] coin_count_ff;
   coin_set_type      coins_ff;
   logic [KIDX_W-1:0] n_active;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [AMT_W-1:0]  min_coins_ff;
   logic              reachable_ff;

   mem_req_type       mem_req;
   logic [CNT_W-1:0]  rd_data;
   logic              seq_idle;
   logic              seq_done;
   logic [CNT_W-1:0]  seq_result;
   logic              take;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coin_count_ff <= '0;
         coins_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_COIN_COUNT) begin
            coin_count_ff <= csr_wdata[KIDX_W-1:0];
         end else if (csr_index >= CSR_COIN_A && csr_index <= CSR_COIN_F) begin
            coins_ff[csr_index - CSR_COIN_A] <= csr_wdata;
         end
      end
   end

   // Counts above the number of coin registers saturate.
   assign n_active = (coin_count_ff > KIDX_W'(MAX_COINS)) ?
                     KIDX_W'(MAX_COINS) : coin_count_ff;

   assign req_ready = seq_idle;

   // Finished result moves into the output register when the slot is free.
   assign take = seq_done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         reachable_ff <= (seq_result != INF_CODE);
         min_coins_ff <= (seq_result != INF_CODE) ? seq_result[AMT_W-1:0] : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_coins = min_coins_ff;
   assign rsp_reachable = reachable_ff;

   ccd_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && req_ready),
      .target   (req_target_amount),
      .n_active (n_active),
      .coins    (coins_ff),
      .rd_data  (rd_data),
      .take     (take),
      .mem_req  (mem_req),
      .idle     (seq_idle),
      .done     (seq_done),
      .result   (seq_result)
   );

   ccd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (TBL_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // An item is only taken while no rebuild is in flight.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !seq_idle)
      else $error("accepted item did not start a rebuild");

   // A result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !take)
      else $error("result register overwritten");

   // An unreachable answer always reports zero coins.
   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reachable) |-> (rsp_min_coins == '0))
      else $error("unreachable result with nonzero count");

endmodule

// ----- tb/tb_min_coin_change_dp.sv -----
// Self-checking testbench for min_coin_change_dp: directed table, then random coin sets.
// Each result is checked against a hand-typed answer or an in-bench minimum coin count predictor.
// Depends on ccd_pkg and the min_coin_change_dp RTL.
module tb_min_coin_change_dp;
   timeunit 1ns;
   timeprecision 1ps;
   import ccd_pkg::*;

   // Worst case is under 120 items, each at most a full 1023 rebuild with six coins, plus stalls.
   localparam int LIMIT_CYCLES = 4_000_000;
   localparam int RANDOM_ITEMS = 84;
   localparam int IDLE_PCT     = 20;
   localparam int TAIL_CYCLES  = 50;

   // Coin registers between A and F, plus one index that maps to nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_B   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_C   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_D   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COIN_E   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [AMT_W-1:0] coins;
      logic             reach;
   } change_type;

   typedef enum logic {ROW_AMT, ROW_CSR} row_kind_type;

   // One directed step: a register write, or an amount with an optional
   // hand-typed answer (otherwise the predictor supplies it).
   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [AMT_W-1:0]     val;
      logic                 known;
      change_type           want;
   } plan_row_type;

   localparam int PLAN_ROWS = 36;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      // out of reset: no coins at all
      '{ROW_AMT, '0, 10'd0,    1'b1, '{10'd0, 1'b1}},
      '{ROW_AMT, '0, 10'd5,    1'b1, '{10'd0, 1'b0}},
      '{ROW_AMT, '0, 10'd1023, 1'b1, '{10'd0, 1'b0}},
      // classic 1/5/10 set
      '{ROW_CSR, CSR_COIN_COUNT, 10'd3,  1'b0, '0},
      '{ROW_CSR, CSR_COIN_A,     10'd1,  1'b0, '0},
      '{ROW_CSR, CSR_COIN_B,     10'd5,  1'b0, '0},
      '{ROW_CSR, CSR_COIN_C,     10'd10, 1'b0, '0},
      '{ROW_AMT, '0, 10'd0,    1'b1, '{10'd0, 1'b1}},
      '{ROW_AMT, '0, 10'd1,    1'b1, '{10'd1, 1'b1}},
      '{ROW_AMT, '0, 10'd11,   1'b1, '{10'd2, 1'b1}},
      '{ROW_AMT, '0, 10'd27,   1'b0, '0},
      '{ROW_AMT, '0, 10'd1023, 1'b0, '0},
      // count of 7 saturates to 6, a zero coin, big coins, stray index write
      '{ROW_CSR, CSR_COIN_COUNT, 10'd7,    1'b0, '0},
      '{ROW_CSR, CSR_COIN_A,     10'd1023, 1'b0, '0},
      '{ROW_CSR, CSR_COIN_B,     10'd0,    1'b0, '0},
      '{ROW_CSR, CSR_COIN_C,     10'd7,    1'b0, '0},
      '{ROW_CSR, CSR_COIN_D,     10'd3,    1'b0, '0},
      '{ROW_CSR, CSR_COIN_E,     10'd512,  1'b0, '0},
      '{ROW_CSR, CSR_COIN_F,     10'd1022, 1'b0, '0},
      '{ROW_CSR, CSR_UNMAPPED,   10'd1,    1'b0, '0},
      '{ROW_AMT, '0, 10'd1023, 1'b1, '{10'd1, 1'b1}},
      // a leaked unit coin from the stray write would make 2 reachable
      '{ROW_AMT, '0, 10'd2,    1'b1, '{10'd0, 1'b0}},
      '{ROW_AMT, '0, 10'd10,   1'b0, '0},
      '{ROW_AMT, '0, 10'd1022, 1'b0, '0},
      '{ROW_AMT, '0, 10'd517,  1'b0, '0},
      // coins loaded but none in use
      '{ROW_CSR, CSR_COIN_COUNT, 10'd0, 1'b0, '0},
      '{ROW_AMT, '0, 10'd3,    1'b1, '{10'd0, 1'b0}},
      '{ROW_AMT, '0, 10'd0,    1'b1, '{10'd0, 1'b1}},
      // single unit coin: largest possible count
      '{ROW_CSR, CSR_COIN_COUNT, 10'd1, 1'b0, '0},
      '{ROW_CSR, CSR_COIN_A,     10'd1, 1'b0, '0},
      '{ROW_AMT, '0, 10'd1023, 1'b1, '{10'd1023, 1'b1}},
      // two coins in use; coin_c = 7 sits beyond the count
      '{ROW_CSR, CSR_COIN_COUNT, 10'd2, 1'b0, '0},
      '{ROW_CSR, CSR_COIN_A,     10'd4, 1'b0, '0},
      '{ROW_CSR, CSR_COIN_B,     10'd6, 1'b0, '0},
      '{ROW_AMT, '0, 10'd7,    1'b1, '{10'd0, 1'b0}},
      '{ROW_AMT, '0, 10'd10,   1'b1, '{10'd2, 1'b1}}
   };

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic [AMT_W-1:0]     req_target_amount = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   logic [AMT_W-1:0]     rsp_min_coins;
   logic                 rsp_reachable;
   logic                 csr_valid         = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index         = '0;
   logic [AMT_W-1:0]     csr_wdata         = '0;

   // shadow of the coin registers as the predictor sees them
   logic [2:0]       coin_count_q = '0;
   logic [AMT_W-1:0] coin_q [MAX_COINS];

   change_type  owed_change [$];
   bit          steady       = 1'b0;  // no idling on either side while set
   int unsigned cycle_count  = 0;
   int          mismatches   = 0;
   int          items_sent   = 0;
   int          results_seen = 0;
   int          unreachable  = 0;
   int          coin_sets    = 0;

   min_coin_change_dp dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_amount (req_target_amount),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_min_coins     (rsp_min_coins),
      .rsp_reachable     (rsp_reachable),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Fewest coins for an amount under the shadow coin set: bottom-up table,
   // amounts no mix reaches hold the infinity code.
   function automatic change_type fewest_coins(input logic [AMT_W-1:0] amt);
      logic [CNT_W-1:0] best [TBL_DEPTH];
      int               active;
      int               cand;
      int               c;
      change_type       r;
      active = (coin_count_q > MAX_COINS) ? MAX_COINS : int'(coin_count_q);
      best[0] = '0;
      for (int a = 1; a <= int'(amt); a++) begin
         cand = int'(INF_CODE);
         for (int k = 0; k < active; k++) begin
            c = int'(coin_q[k]);
            if (c != 0 && c <= a && best[a-c] != INF_CODE && int'(best[a-c]) + 1 < cand)
               cand = int'(best[a-c]) + 1;
         end
         best[a] = CNT_W'(cand);
      end
      if (best[amt] == INF_CODE) r = '{'0, 1'b0};
      else r = '{best[amt][AMT_W-1:0], 1'b1};
      return r;
   endfunction

   function automatic logic [AMT_W-1:0] pick_coin();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return AMT_W'($urandom_range(1, 1023));
      return AMT_W'($urandom_range(1, 24));
   endfunction

   // mostly short tables, now and then a full-range amount
   function automatic logic [AMT_W-1:0] pick_target();
      if ($urandom_range(0, 11) == 0) return AMT_W'($urandom_range(0, 1023));
      return AMT_W'($urandom_range(0, 120));
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   // Register write; the shadow follows at the accepting edge.
   task automatic put_csr(input logic [CSR_IDX_W-1:0] idx, input logic [AMT_W-1:0] data);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_COIN_COUNT) coin_count_q = data[2:0];
      else if (idx >= CSR_COIN_A && idx <= CSR_COIN_F) coin_q[idx - CSR_COIN_A] = data;
   endtask

   // Valid stays up across back-to-back items; it only drops for a gap.
   task automatic offer_amount(input logic [AMT_W-1:0] amt, input logic known,
                               input change_type want);
      change_type owed;
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_target_amount <= amt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      owed = known ? want : fewest_coins(amt);
      if (!owed.reach) unreachable++;
      owed_change.push_back(owed);
      items_sent++;
   endtask

   // Hold off the sender until every owed result is back; the block is idle then.
   task automatic settle();
      req_valid <= 1'b0;
      while (owed_change.size() != 0) @(posedge clock);
   endtask

   // Receiver stalls at random except during the steady stretch.
   always @(posedge clock)
      rsp_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

   always @(posedge clock) begin
      change_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (owed_change.size() == 0) begin
            flag_mismatch($sformatf("result with nothing owed: coins %0d reach %0b",
                                    rsp_min_coins, rsp_reachable));
         end else begin
            want = owed_change.pop_front();
            results_seen++;
            if (rsp_min_coins !== want.coins)
               flag_mismatch($sformatf("min_coins %0d, want %0d", rsp_min_coins, want.coins));
            if (rsp_reachable !== want.reach)
               flag_mismatch($sformatf("reachable %0b, want %0b", rsp_reachable, want.reach));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results owed", cycle_count,
                  owed_change.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      bit in_burst;
      int phase;
      int random_sent;
      int n_items;
      int directed_sent;
      in_burst    = 1'b0;
      phase       = 0;
      random_sent = 0;
      foreach (coin_q[k]) coin_q[k] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed table. A run of register writes waits for the block to drain.
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            if (!in_burst) begin
               settle();
               in_burst = 1'b1;
               coin_sets++;
            end
            put_csr(directed_plan[i].idx, directed_plan[i].val);
         end else begin
            if (in_burst) begin
               csr_valid <= 1'b0;
               in_burst = 1'b0;
            end
            offer_amount(directed_plan[i].val, directed_plan[i].known, directed_plan[i].want);
         end
      end
      directed_sent = items_sent;

      // Random coin sets, each followed by a burst of amounts. Phase 2 runs
      // with no idling; phase 4 drains in the middle of its burst.
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         steady = (phase == 2);
         put_csr(CSR_COIN_COUNT, AMT_W'($urandom_range(0, 7)));
         for (int k = 0; k < MAX_COINS; k++)
            put_csr(CSR_IDX_W'(CSR_COIN_A + k), pick_coin());
         if ($urandom_range(0, 2) == 0) put_csr(CSR_UNMAPPED, AMT_W'($urandom));
         csr_valid <= 1'b0;
         coin_sets++;
         n_items = (phase == 2) ? 24 : $urandom_range(8, 16);
         for (int i = 0; i < n_items; i++) begin
            if (phase == 4 && i == n_items / 2) settle();
            offer_amount(pick_target(), 1'b0, '0);
            random_sent++;
         end
         phase++;
      end
      settle();
      steady = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("tb: %0d amounts (%0d directed), %0d results checked, %0d unreachable",
               items_sent, directed_sent, results_seen, unreachable);
      $display("tb: %0d coin settings, %0d cycles, %0d mismatches",
               coin_sets, cycle_count, mismatches);
      if (mismatches == 0 && owed_change.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
